@@ rtl/sagp_pkg.sv @@
// ----------------------------------------------------------------------------
// sagp_pkg
// Types, widths and constants shared by the spatial gain and pan pipeline.
// ----------------------------------------------------------------------------
package sagp_pkg;

   // Fixed formats
   localparam int POS_WIDTH        = 24;
   localparam int GAIN_FRAC_BITS   = 15;
   localparam int TRIG_TABLE_DEPTH = 256;

   localparam int RVEC_W  = 16;
   localparam int DIFF_W  = POS_WIDTH + 1;
   localparam int SQ_W    = 2 * DIFF_W - 1;
   localparam int SUM_W   = 2 * DIFF_W;
   localparam int DIST_W  = DIFF_W;
   localparam int PRD_W   = RVEC_W + DIFF_W;
   localparam int DOT_W   = PRD_W + 2;
   localparam int MAG_W   = DOT_W - 1;
   localparam int HALF_W  = (MAG_W + 1) / 2;
   localparam int PPRD_W  = HALF_W + 16;

   // Register widths
   localparam int REF_W   = 13;
   localparam int MAXD_W  = 17;
   localparam int PW_W    = 16;
   localparam int ABS_W   = 16;
   localparam int VOL_W   = 17;
   localparam int SPAN_W  = 17;

   // Divider operand widths
   localparam int QUO_W   = 20;
   localparam int ANUM0_W = REF_W + SPAN_W;
   localparam int ANUM_W  = ANUM0_W + GAIN_FRAC_BITS;
   localparam int ADEN_W  = DIST_W + SPAN_W;
   localparam int PNUM_W  = MAG_W + PW_W;
   localparam int PDEN_W  = DIST_W + 14;
   localparam int FNUM_W  = DIST_W + 15;
   localparam int FDEN_W  = MAXD_W;

   // Result widths
   localparam int ATT_W   = GAIN_FRAC_BITS + 1;
   localparam int GAIN_W  = 17;
   localparam int CUT_W   = 16;
   localparam int TRIG_W  = 16;
   localparam int K_W     = $clog2(TRIG_TABLE_DEPTH + 1);

   // Constants
   localparam int Q15_ONE      = 32768;
   localparam int UNITY_GAIN   = 1 << GAIN_FRAC_BITS;
   localparam int GAIN_SAT     = 2 << GAIN_FRAC_BITS;
   localparam int CUT_MIN      = 1638;
   localparam int SPAN_MIN     = 256;
   localparam int MAXD_MIN     = 256;
   localparam int PAN_DIST_MIN = 2;
   localparam int ABSORB_MIN   = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_DISTANCE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AIR_ABSORB    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_VOLUME = 3'd4;

   localparam logic [REF_W-1:0]  REF_RESET    = 13'd1280;
   localparam logic [MAXD_W-1:0] MAXD_RESET   = 17'd25600;
   localparam logic [PW_W-1:0]   PW_RESET     = 16'd32768;
   localparam logic [ABS_W-1:0]  ABS_RESET    = 16'd16384;
   localparam logic [VOL_W-1:0]  VOL_RESET    = 17'd32768;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] src_x;
      logic signed [POS_WIDTH-1:0] src_y;
      logic signed [POS_WIDTH-1:0] src_z;
      logic signed [POS_WIDTH-1:0] lis_x;
      logic signed [POS_WIDTH-1:0] lis_y;
      logic signed [POS_WIDTH-1:0] lis_z;
      logic signed [RVEC_W-1:0]    right_x;
      logic signed [RVEC_W-1:0]    right_y;
      logic signed [RVEC_W-1:0]    right_z;
   } req_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0] left_gain;
      logic [GAIN_W-1:0] right_gain;
      logic              filter_update;
      logic [CUT_W-1:0]  filter_cutoff;
   } rsp_payload_type;

   // Quarter-wave sine, sin(pi/2 * k/depth) in Q.15, odd degree-9 polynomial
   typedef logic [TRIG_W-1:0] trig_tab_type [0:TRIG_TABLE_DEPTH];

   function automatic trig_tab_type build_trig_table();
      longint x, x2, p, s;
      trig_tab_type t;
      for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
         x  = (longint'(k) <<< 30) / TRIG_TABLE_DEPTH;
         x2 = (x * x) / 64'sd1073741824;
         p  = 64'sd172273;
         p  = -64'sd5026995 + (p * x2) / 64'sd1073741824;
         p  = 64'sd85569306 + (p * x2) / 64'sd1073741824;
         p  = -64'sd693598668 + (p * x2) / 64'sd1073741824;
         p  = 64'sd1686629713 + (p * x2) / 64'sd1073741824;
         s  = (p * x) / 64'sd1073741824;
         s  = (s + 64'sd16384) / 64'sd32768;
         if (s < 0) begin
            s = 0;
         end
         if (s > Q15_ONE) begin
            s = Q15_ONE;
         end
         t[k] = TRIG_W'(s);
      end
      return t;
   endfunction

   localparam trig_tab_type TRIG_TABLE = build_trig_table();

endpackage

@@ rtl/spatial_audio_gain_pan.sv @@
// ----------------------------------------------------------------------------
// spatial_audio_gain_pan
// Distance attenuation, equal-power stereo pan and air-absorption cutoff for
// one sound source per item.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock while the pipeline is not stalled.
// An accepted item passes the 25-stage square root (one root bit per stage)
// and then three 20-stage dividers that run side by side (attenuation,
// pan, filter distance ratio), plus ten stages of setup, multiply and table
// lookup and the output register. The pipeline stalls as a whole only when
// both the output register and its skid register are full. Configuration
// registers are read live and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module spatial_audio_gain_pan (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sagp_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sagp_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [sagp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sagp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import sagp_pkg::*;

   typedef struct packed {
      logic above;
      logic pan_on;
      logic pan_neg;
      logic fsat;
   } side_type;

   logic en;

   // Configuration registers
   logic [REF_W-1:0]  ref_ff;
   logic [MAXD_W-1:0] maxd_ff;
   logic [PW_W-1:0]   pw_ff;
   logic [ABS_W-1:0]  absorb_ff;
   logic [VOL_W-1:0]  vol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= REF_RESET;
         maxd_ff   <= MAXD_RESET;
         pw_ff     <= PW_RESET;
         absorb_ff <= ABS_RESET;
         vol_ff    <= VOL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_DISTANCE:  ref_ff    <= csr_wdata[REF_W-1:0];
            CSR_MAX_DISTANCE:  maxd_ff   <= csr_wdata[MAXD_W-1:0];
            CSR_PAN_WIDTH:     pw_ff     <= csr_wdata[PW_W-1:0];
            CSR_AIR_ABSORB:    absorb_ff <= csr_wdata[ABS_W-1:0];
            CSR_MASTER_VOLUME: vol_ff    <= csr_wdata[VOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage 0: offset vector and right vector
   logic                     v0_ff;
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [RVEC_W-1:0] r_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
      if (en) begin
         d_ff[0] <= {req_data.src_x[POS_WIDTH-1], req_data.src_x}
                  - {req_data.lis_x[POS_WIDTH-1], req_data.lis_x};
         d_ff[1] <= {req_data.src_y[POS_WIDTH-1], req_data.src_y}
                  - {req_data.lis_y[POS_WIDTH-1], req_data.lis_y};
         d_ff[2] <= {req_data.src_z[POS_WIDTH-1], req_data.src_z}
                  - {req_data.lis_z[POS_WIDTH-1], req_data.lis_z};
         r_ff[0] <= req_data.right_x;
         r_ff[1] <= req_data.right_y;
         r_ff[2] <= req_data.right_z;
      end
   end

   // Stage 1: squares and dot-product terms
   logic                      v1_ff;
   logic [SQ_W-1:0]           sq_ff  [3];
   logic signed [PRD_W-1:0]   prd_ff [3];
   logic signed [2*DIFF_W-1:0] sq_full [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_full[i] = d_ff[i] * d_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]  <= sq_full[i][SQ_W-1:0];
            prd_ff[i] <= PRD_W'(r_ff[i]) * PRD_W'(d_ff[i]);
         end
      end
   end

   // Stage 2: sum of squares and dot product
   logic                    v2_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic signed [DOT_W-1:0] dot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         dot_ff <= DOT_W'(prd_ff[0]) + DOT_W'(prd_ff[1]) + DOT_W'(prd_ff[2]);
      end
   end

   // Square root, with valid and dot product carried alongside
   logic [DIST_W-1:0]       root;
   logic                    vq_ff [DIST_W];
   logic signed [DOT_W-1:0] dq_ff [DIST_W];

   sagp_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (sum_ff),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIST_W; s++) begin
            vq_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vq_ff[0] <= v2_ff;
         for (int s = 1; s < DIST_W; s++) begin
            vq_ff[s] <= vq_ff[s-1];
         end
      end
      if (en) begin
         dq_ff[0] <= dot_ff;
         for (int s = 1; s < DIST_W; s++) begin
            dq_ff[s] <= dq_ff[s-1];
         end
      end
   end

   // Stage 3: span, fade, direction magnitude, flags
   logic                    v3_ff;
   logic [DIST_W-1:0]       dist3_ff;
   logic [SPAN_W-1:0]       span3_ff;
   logic [SPAN_W-1:0]       fn3_ff;
   logic [MAG_W-1:0]        mag3_ff;
   logic [MAXD_W-1:0]       md3_ff;
   side_type                side3_ff;
   logic [DIST_W:0]         excess;
   logic [MAXD_W:0]         span_raw;
   logic                    span_small;
   logic [SPAN_W-1:0]       span_in;
   logic [SPAN_W-1:0]       fn_in;
   logic signed [DOT_W-1:0] dot_q;
   logic [DOT_W-1:0]        dot_abs;
   side_type                side_in;

   always_comb begin
      dot_q      = dq_ff[DIST_W-1];
      excess     = {1'b0, root} - (DIST_W+1)'(ref_ff);
      span_raw   = {1'b0, maxd_ff} - (MAXD_W+1)'(ref_ff);
      span_small = ({1'b0, maxd_ff} < ((MAXD_W+1)'(ref_ff) + (MAXD_W+1)'(SPAN_MIN)));
      span_in    = span_small ? SPAN_W'(SPAN_MIN) : span_raw[SPAN_W-1:0];
      if (excess > (DIST_W+1)'(span_in)) begin
         fn_in = '0;
      end else begin
         fn_in = span_in - excess[SPAN_W-1:0];
      end
      dot_abs         = dot_q[DOT_W-1] ? -dot_q : dot_q;
      side_in.above   = (root > DIST_W'(ref_ff));
      side_in.pan_on  = (root > DIST_W'(PAN_DIST_MIN));
      side_in.pan_neg = dot_q[DOT_W-1];
      if (maxd_ff < MAXD_W'(MAXD_MIN)) begin
         side_in.fsat = (root >= DIST_W'(MAXD_MIN));
      end else begin
         side_in.fsat = (root >= DIST_W'(maxd_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= vq_ff[DIST_W-1];
      end
      if (en) begin
         dist3_ff <= root;
         span3_ff <= span_in;
         fn3_ff   <= fn_in;
         mag3_ff  <= dot_abs[MAG_W-1:0];
         md3_ff   <= (maxd_ff < MAXD_W'(MAXD_MIN)) ? MAXD_W'(MAXD_MIN) : maxd_ff;
         side3_ff <= side_in;
      end
   end

   // Stage 4: products for the divider operands
   logic                v4_ff;
   logic [ANUM0_W-1:0]  anum4_ff;
   logic [ADEN_W-1:0]   aden4_ff;
   logic [PPRD_W-1:0]   plo4_ff;
   logic [PPRD_W-1:0]   phi4_ff;
   logic [DIST_W-1:0]   dist4_ff;
   logic [MAXD_W-1:0]   md4_ff;
   side_type            side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         anum4_ff <= ANUM0_W'(ref_ff) * ANUM0_W'(fn3_ff);
         aden4_ff <= ADEN_W'(dist3_ff) * ADEN_W'(span3_ff);
         plo4_ff  <= PPRD_W'(mag3_ff[HALF_W-1:0]) * PPRD_W'(pw_ff);
         phi4_ff  <= PPRD_W'(mag3_ff[MAG_W-1:HALF_W]) * PPRD_W'(pw_ff);
         dist4_ff <= dist3_ff;
         md4_ff   <= md3_ff;
         side4_ff <= side3_ff;
      end
   end

   // Stage 5: assemble numerators and denominators
   logic              v5_ff;
   logic [ANUM_W-1:0] anum5_ff;
   logic [ADEN_W-1:0] aden5_ff;
   logic [PNUM_W-1:0] pnum5_ff;
   logic [PDEN_W-1:0] pden5_ff;
   logic [FNUM_W-1:0] fnum5_ff;
   logic [FDEN_W-1:0] fden5_ff;
   side_type          side5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         anum5_ff <= ANUM_W'(anum4_ff) << GAIN_FRAC_BITS;
         aden5_ff <= aden4_ff;
         pnum5_ff <= (PNUM_W'(phi4_ff) << HALF_W) + PNUM_W'(plo4_ff);
         pden5_ff <= PDEN_W'(dist4_ff) << 14;
         fnum5_ff <= FNUM_W'(dist4_ff) << 15;
         fden5_ff <= md4_ff;
         side5_ff <= side4_ff;
      end
   end

   // Three dividers in lockstep, flags carried alongside
   logic [QUO_W-1:0] q_att;
   logic [QUO_W-1:0] q_pan;
   logic [QUO_W-1:0] q_flt;
   logic             vd_ff [QUO_W];
   side_type         sd_ff [QUO_W];

   sagp_div #(.NUM_W(ANUM_W), .DEN_W(ADEN_W), .QUO_W(QUO_W)) u_att_div (
      .clock (clock),
      .en    (en),
      .num   (anum5_ff),
      .den   (aden5_ff),
      .quo   (q_att)
   );

   sagp_div #(.NUM_W(PNUM_W), .DEN_W(PDEN_W), .QUO_W(QUO_W)) u_pan_div (
      .clock (clock),
      .en    (en),
      .num   (pnum5_ff),
      .den   (pden5_ff),
      .quo   (q_pan)
   );

   sagp_div #(.NUM_W(FNUM_W), .DEN_W(FDEN_W), .QUO_W(QUO_W)) u_flt_div (
      .clock (clock),
      .en    (en),
      .num   (fnum5_ff),
      .den   (fden5_ff),
      .quo   (q_flt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QUO_W; s++) begin
            vd_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vd_ff[0] <= v5_ff;
         for (int s = 1; s < QUO_W; s++) begin
            vd_ff[s] <= vd_ff[s-1];
         end
      end
      if (en) begin
         sd_ff[0] <= side5_ff;
         for (int s = 1; s < QUO_W; s++) begin
            sd_ff[s] <= sd_ff[s-1];
         end
      end
   end

   // Stage 6: raw attenuation, pan position, distance ratio
   logic              v6_ff;
   logic [ATT_W-1:0]  att6_ff;
   logic [16:0]       p6_ff;
   logic [15:0]       f6_ff;
   side_type          sd;
   logic [15:0]       pmag;

   always_comb begin
      sd = sd_ff[QUO_W-1];
      if (!sd.pan_on) begin
         pmag = '0;
      end else if (q_pan > QUO_W'(Q15_ONE)) begin
         pmag = 16'(Q15_ONE);
      end else begin
         pmag = q_pan[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= vd_ff[QUO_W-1];
      end
      if (en) begin
         att6_ff <= sd.above ? ATT_W'(q_att[GAIN_FRAC_BITS-1:0]) : ATT_W'(UNITY_GAIN);
         p6_ff   <= sd.pan_neg ? (17'(Q15_ONE) - 17'(pmag)) : (17'(Q15_ONE) + 17'(pmag));
         f6_ff   <= sd.fsat ? 16'(Q15_ONE) : {1'b0, q_flt[14:0]};
      end
   end

   // Stage 7: master volume, table index, squared ratio
   logic               v7_ff;
   logic [GAIN_W-1:0]  att7_ff;
   logic [K_W-1:0]     k7_ff;
   logic [15:0]        f2_7_ff;
   logic [ATT_W+VOL_W-1:0] vprod;
   logic [31:0]        kprod;
   logic [31:0]        fprod;

   assign vprod = (ATT_W+VOL_W)'(att6_ff) * (ATT_W+VOL_W)'(vol_ff);
   assign kprod = 32'(p6_ff) * 32'(TRIG_TABLE_DEPTH) + 32'(Q15_ONE);
   assign fprod = 32'(f6_ff) * 32'(f6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
      if (en) begin
         att7_ff <= vprod[15 +: GAIN_W];
         k7_ff   <= kprod[16 +: K_W];
         f2_7_ff <= fprod[15 +: 16];
      end
   end

   // Stage 8: sine lookups and absorption loss
   logic               v8_ff;
   logic [TRIG_W-1:0]  lt8_ff;
   logic [TRIG_W-1:0]  rt8_ff;
   logic [15:0]        loss8_ff;
   logic [GAIN_W-1:0]  att8_ff;
   logic [31:0]        aprod;

   assign aprod = 32'(absorb_ff) * 32'(f2_7_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
      if (en) begin
         rt8_ff   <= TRIG_TABLE[k7_ff];
         lt8_ff   <= TRIG_TABLE[K_W'(TRIG_TABLE_DEPTH) - k7_ff];
         loss8_ff <= aprod[15 +: 16];
         att8_ff  <= att7_ff;
      end
   end

   // Stage 9: gains, saturation, cutoff clamp
   logic                        v9_ff;
   rsp_payload_type             res9_ff;
   rsp_payload_type             res_in;
   logic [TRIG_W+GAIN_W-1:0]    lprod;
   logic [TRIG_W+GAIN_W-1:0]    rprod;
   logic [TRIG_W+GAIN_W-16:0]   lsh;
   logic [TRIG_W+GAIN_W-16:0]   rsh;

   always_comb begin
      lprod = (TRIG_W+GAIN_W)'(lt8_ff) * (TRIG_W+GAIN_W)'(att8_ff);
      rprod = (TRIG_W+GAIN_W)'(rt8_ff) * (TRIG_W+GAIN_W)'(att8_ff);
      lsh   = lprod[TRIG_W+GAIN_W-1:15];
      rsh   = rprod[TRIG_W+GAIN_W-1:15];
      res_in.left_gain  = (lsh > (TRIG_W+GAIN_W-15)'(GAIN_SAT)) ? GAIN_W'(GAIN_SAT)
                                                                 : lsh[GAIN_W-1:0];
      res_in.right_gain = (rsh > (TRIG_W+GAIN_W-15)'(GAIN_SAT)) ? GAIN_W'(GAIN_SAT)
                                                                 : rsh[GAIN_W-1:0];
      res_in.filter_update = (absorb_ff > ABS_W'(ABSORB_MIN));
      if (!res_in.filter_update) begin
         res_in.filter_cutoff = CUT_W'(Q15_ONE);
      end else if (loss8_ff > 16'(Q15_ONE - CUT_MIN)) begin
         res_in.filter_cutoff = CUT_W'(CUT_MIN);
      end else begin
         res_in.filter_cutoff = CUT_W'(Q15_ONE) - loss8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= v8_ff;
      end
      if (en) begin
         res9_ff <= res_in;
      end
   end

   // Output register with skid: the pipeline keeps moving while one
   // result waits, and stalls only once the skid holds another
   logic            rsp_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type skid_data_ff;
   logic            xfer;

   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign xfer      = en && v9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= xfer;
         end
      end else if (xfer) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : res9_ff;
      end else if (xfer) begin
         skid_data_ff <= res9_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/sagp_sqrt.sv @@
// ----------------------------------------------------------------------------
// sagp_sqrt
// Pipelined integer square root, one result bit per stage (floor).
// ----------------------------------------------------------------------------
module sagp_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [sagp_pkg::SUM_W-1:0]  rad,
   output logic [sagp_pkg::DIST_W-1:0] root
);
   import sagp_pkg::*;

   localparam int ROOT_W = DIST_W;
   localparam int REM_W  = ROOT_W + 3;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SUM_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [SUM_W-1:0]  rad_in  [ROOT_W];

   // One digit step per stage: bring down two radicand bits, try 4r+1
   always_comb begin
      logic [REM_W-1:0]  rem_p;
      logic [REM_W-1:0]  rem_sh;
      logic [ROOT_W-1:0] root_p;
      logic [SUM_W-1:0]  rad_p;
      logic [REM_W-1:0]  trial;
      for (int s = 0; s < ROOT_W; s++) begin
         if (s == 0) begin
            rem_p  = '0;
            root_p = '0;
            rad_p  = rad;
         end else begin
            rem_p  = rem_ff[s-1];
            root_p = root_ff[s-1];
            rad_p  = rad_ff[s-1];
         end
         rem_sh = {rem_p[REM_W-3:0], rad_p[SUM_W-1 -: 2]};
         trial  = REM_W'({root_p, 2'b01});
         if (rem_sh >= trial) begin
            rem_in[s]  = rem_sh - trial;
            root_in[s] = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = rem_sh;
            root_in[s] = {root_p[ROOT_W-2:0], 1'b0};
         end
         rad_in[s] = {rad_p[SUM_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < ROOT_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            rad_ff[s]  <= rad_in[s];
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

@@ rtl/sagp_div.sv @@
// ----------------------------------------------------------------------------
// sagp_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// expected to fit in QUO_W bits; otherwise the result is not meaningful.
// ----------------------------------------------------------------------------
module sagp_div #(
   parameter int NUM_W = 45,
   parameter int DEN_W = 42,
   parameter int QUO_W = 20
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [DEN_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] low_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];
   logic [DEN_W-1:0] den_in [QUO_W];
   logic [NUM_W-1:0] num_hi;

   assign num_hi = num >> QUO_W;

   // Shift in one numerator bit, subtract the divisor when it fits
   always_comb begin
      logic [DEN_W-1:0] rem_p;
      logic [QUO_W-1:0] low_p;
      logic [QUO_W-1:0] quo_p;
      logic [DEN_W-1:0] den_p;
      logic [DEN_W:0]   cat;
      logic [DEN_W:0]   diff;
      logic             ge;
      for (int s = 0; s < QUO_W; s++) begin
         if (s == 0) begin
            rem_p = num_hi[DEN_W-1:0];
            low_p = num[QUO_W-1:0];
            quo_p = '0;
            den_p = den;
         end else begin
            rem_p = rem_ff[s-1];
            low_p = low_ff[s-1];
            quo_p = quo_ff[s-1];
            den_p = den_ff[s-1];
         end
         cat  = {rem_p, low_p[QUO_W-1]};
         diff = cat - {1'b0, den_p};
         ge   = (cat >= {1'b0, den_p});
         rem_in[s] = ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
         low_in[s] = {low_p[QUO_W-2:0], 1'b0};
         quo_in[s] = {quo_p[QUO_W-2:0], ge};
         den_in[s] = den_p;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QUO_W; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= den_in[s];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule
